/* rtl/rpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types and constants for the run-length pixel decoder.
// ----------------------------------------------------------------------------
package rpd_pkg;

   localparam int OUT_LANES  = 4;
   localparam int COUNT_BITS = 24;

   localparam int BYTE_W   = 8;
   localparam int PIXEL_W  = 32;
   localparam int COPIES_W = 3;
   localparam int BPP_W    = 3;
   localparam int LEFT_W   = 8;
   localparam int IDX_W    = 2;
   localparam int CSR_W    = COUNT_BITS;

   // Configuration register indexes.
   localparam logic CSR_BYTES_PER_PIXEL = 1'b0;
   localparam logic CSR_PIXEL_COUNT     = 1'b1;

   // A control byte of this value is treated as a single literal.
   localparam logic [BYTE_W-1:0] CTRL_NOP = 8'h80;

   typedef struct packed {
      logic [BYTE_W-1:0] stream_byte;
      logic              first_byte;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]  pixel_value;
      logic [COPIES_W-1:0] copies;
      logic                image_done;
      logic                overrun_error;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic accept;   // Take the presented input byte.
      logic emit;     // Produce one result beat into the output register.
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic pixel_done;  // The presented byte completes a pixel.
      logic emit_last;   // The beat being produced ends this pixel's results.
   } status_type;

endpackage

/* rtl/rpd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_ctrl
// Sequencer: takes bytes, then steps through result beats of a finished pixel.
// ----------------------------------------------------------------------------
module rpd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                csr_ready,
   input  rpd_pkg::status_type status,
   output rpd_pkg::cmd_type    cmd
);
   import rpd_pkg::*;

   typedef enum logic {
      ST_ACCEPT,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cmd.accept = (state_ff == ST_ACCEPT) && req_valid;
   assign cmd.emit   = (state_ff == ST_EMIT) && out_free;
   assign req_stall  = (state_ff != ST_ACCEPT);
   assign csr_ready  = (state_ff == ST_ACCEPT);
   assign rsp_valid  = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCEPT;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_ACCEPT: begin
               if (cmd.accept && status.pixel_done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (cmd.emit && status.emit_last) begin
                  state_ff <= ST_ACCEPT;
               end
            end
            default: state_ff <= ST_ACCEPT;
         endcase
      end
   end

endmodule

/* rtl/rpd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_datapath
// Decoder state, pixel assembly, beat sizing and the result register.
// ----------------------------------------------------------------------------
module rpd_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  rpd_pkg::req_type                req_data,
   output rpd_pkg::rsp_type                rsp_data,
   input  logic                            csr_write,
   input  logic                            csr_index,
   input  logic [rpd_pkg::CSR_W-1:0]       csr_data,
   input  rpd_pkg::cmd_type                cmd,
   output rpd_pkg::status_type             status
);
   import rpd_pkg::*;

   // Configuration.
   logic [BPP_W-1:0]      bpp_ff;
   logic [COUNT_BITS-1:0] count_ff;

   // Decoder state.
   logic                  active_ff, active_in;
   logic                  expect_ff, expect_in;
   logic                  run_ff, run_in;
   logic [LEFT_W-1:0]     left_ff, left_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [PIXEL_W-1:0]    asm_ff, asm_in;
   logic [COUNT_BITS-1:0] emitted_ff, emitted_in;
   logic [PIXEL_W-1:0]    value_ff, value_in;
   rsp_type               rsp_ff, rsp_in;

   // Effective view of the state for the presented byte.
   logic                  eff_active, eff_expect;
   logic [IDX_W-1:0]      eff_idx;
   logic [BPP_W-1:0]      eff_bpp;
   logic                  idx_last;
   logic [BYTE_W-1:0]     ctrl_byte;
   logic [LEFT_W:0]       run_len;
   logic [PIXEL_W-1:0]    asm_next;

   // Beat sizing.
   logic [COUNT_BITS-1:0] room, lane_cap, k_left, k_beat;
   logic [COUNT_BITS-1:0] emitted_next;
   logic [LEFT_W-1:0]     left_next;
   logic                  overrun, done_next;

   assign eff_bpp    = (bpp_ff >= 3'd1 && bpp_ff <= 3'd4) ? bpp_ff : 3'd4;
   assign eff_active = req_data.first_byte ? (count_ff != '0) : active_ff;
   assign eff_expect = req_data.first_byte | expect_ff;
   assign eff_idx    = req_data.first_byte ? '0 : idx_ff;
   assign idx_last   = ({1'b0, eff_idx} + 3'd1) >= eff_bpp;
   assign ctrl_byte  = (req_data.stream_byte == CTRL_NOP) ? '0 : req_data.stream_byte;
   assign run_len    = 9'd257 - {1'b0, ctrl_byte};
   assign asm_next   = (eff_idx == '0) ? {{(PIXEL_W-BYTE_W){1'b0}}, req_data.stream_byte}
                                       : {asm_ff[PIXEL_W-BYTE_W-1:0], req_data.stream_byte};

   assign status.pixel_done = eff_active && !eff_expect && idx_last;

   // One beat takes the smallest of the lane limit, the packet rest and the room
   // left in the image.
   assign room         = count_ff - emitted_ff;
   assign overrun      = emitted_ff >= count_ff;
   assign lane_cap     = run_ff ? COUNT_BITS'(OUT_LANES) : COUNT_BITS'(1);
   assign k_left       = ({{(COUNT_BITS-LEFT_W){1'b0}}, left_ff} < lane_cap)
                         ? {{(COUNT_BITS-LEFT_W){1'b0}}, left_ff} : lane_cap;
   assign k_beat       = (room < k_left) ? room : k_left;
   assign emitted_next = emitted_ff + k_beat;
   assign left_next    = left_ff - k_beat[LEFT_W-1:0];
   assign done_next    = emitted_next >= count_ff;

   assign status.emit_last = overrun || (left_next == '0) || (!run_ff && !done_next);

   always_comb begin
      active_in  = active_ff;
      expect_in  = expect_ff;
      run_in     = run_ff;
      left_in    = left_ff;
      idx_in     = idx_ff;
      asm_in     = asm_ff;
      emitted_in = emitted_ff;
      value_in   = value_ff;
      rsp_in     = rsp_ff;
      if (cmd.accept) begin
         if (req_data.first_byte) begin
            active_in  = eff_active;
            expect_in  = 1'b1;
            run_in     = 1'b0;
            left_in    = '0;
            idx_in     = '0;
            asm_in     = '0;
            emitted_in = '0;
         end
         if (eff_active) begin
            if (eff_expect) begin
               if (ctrl_byte[BYTE_W-1]) begin
                  run_in  = 1'b1;
                  left_in = run_len[LEFT_W-1:0];
               end else begin
                  run_in  = 1'b0;
                  left_in = ctrl_byte + 8'd1;
               end
               expect_in = 1'b0;
               idx_in    = '0;
            end else begin
               asm_in = asm_next;
               if (!idx_last) begin
                  idx_in = eff_idx + 2'd1;
               end else begin
                  idx_in = '0;
                  unique case (eff_bpp)
                     3'd1:    value_in = asm_next & 32'h0000_00ff;
                     3'd2:    value_in = asm_next & 32'h0000_ffff;
                     3'd3:    value_in = asm_next & 32'h00ff_ffff;
                     default: value_in = asm_next;
                  endcase
               end
            end
         end
      end else if (cmd.emit) begin
         if (overrun) begin
            rsp_in.pixel_value   = '0;
            rsp_in.copies        = '0;
            rsp_in.image_done    = 1'b0;
            rsp_in.overrun_error = 1'b1;
            active_in            = 1'b0;
         end else begin
            rsp_in.pixel_value   = value_ff;
            rsp_in.copies        = k_beat[COPIES_W-1:0];
            rsp_in.image_done    = done_next;
            rsp_in.overrun_error = 1'b0;
            emitted_in           = emitted_next;
            left_in              = left_next;
            if (left_next == '0) begin
               if (done_next) begin
                  active_in = 1'b0;
               end else begin
                  expect_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff     <= 3'd1;
         count_ff   <= COUNT_BITS'(1);
         active_ff  <= 1'b0;
         expect_ff  <= 1'b1;
         run_ff     <= 1'b0;
         left_ff    <= '0;
         idx_ff     <= '0;
         emitted_ff <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_BYTES_PER_PIXEL: bpp_ff   <= csr_data[BPP_W-1:0];
               CSR_PIXEL_COUNT:     count_ff <= csr_data[COUNT_BITS-1:0];
               default:             bpp_ff   <= bpp_ff;
            endcase
         end
         active_ff  <= active_in;
         expect_ff  <= expect_in;
         run_ff     <= run_in;
         left_ff    <= left_in;
         idx_ff     <= idx_in;
         emitted_ff <= emitted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asm_ff <= '0;
      end else begin
         asm_ff <= asm_in;
      end
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

/* rtl/rle_pixel_run_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pixel_run_decoder
// PackBits style run-length decoder for pixels of one to four bytes.
// ----------------------------------------------------------------------------
// Usage: compressed bytes enter on the req_ channel, one byte per transaction;
// first_byte marks the control byte that opens a new image. Decoded beats leave
// on the rsp_ channel, each one pixel value with one to four copies, image_done
// on the beat holding the image's final pixel, or an overrun_error beat.
// Control bytes and all but the last byte of a pixel are taken and give no
// result. The byte that completes a pixel is taken, then the input stalls while
// beats are produced: one beat for each literal pixel, ceil(n/4) beats for a
// run of n pixels, plus one overrun_error beat if the pixel count is exceeded.
// The first beat enters the output register after the pixel value is registered,
// once that register is free. A stalled receiver holds the output register and the
// beat sequence waits; the input keeps accepting bytes while the last beat is held.
// Registers bytes_per_pixel (index 0) and pixel_count (index 1) must be written
// through the csr_ port only between images; the block does not enforce this.
// Reset sets both to 1, idles the decoder until a first byte, empties the output register.
// ----------------------------------------------------------------------------
module rle_pixel_run_decoder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  rpd_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output rpd_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [rpd_pkg::CSR_W-1:0]   csr_data
);
   import rpd_pkg::*;

   cmd_type    cmd;
   status_type status;

   rpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rpd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
